// ===== src/sida_pkg.sv =====
// Shared types and constants for the signed integer to decimal text converter.
package sida_pkg;

  localparam int DigitMax = 10;
  localparam int DigitW = $clog2(DigitMax);

  localparam logic [5:0] CharZero  = 6'd48;
  localparam logic [5:0] CharMinus = 6'd45;

  // floor(x / 10) == (x * Recip) >> RecipShift for every 32-bit unsigned x.
  localparam logic [31:0] Recip = 32'hCCCC_CCCD;
  localparam int RecipShift = 35;

  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
  } sida_item_t;

endpackage

// ===== src/signed_int_to_decimal_ascii.sv =====
// Top level: signed 32-bit integer to decimal ASCII text, one character per beat.
//
//   Channel  Direction  Handshake                 Payload
//   value    in         value_valid / value_stall value[31:0] signed
//   text     out        text_valid / text_stall   character[5:0], last
//
// An item is fetched, then divided by ten once per digit (a 32x32 reciprocal
// multiply, then the remainder), then sent out one character per beat, with a
// minus sign first for a negative value.
// The front end and queue keep taking beats while the converter works.
// Reset is synchronous; it empties the queue and drops any item in flight.
// A stall on text holds the output register and pauses the converter only.
module signed_int_to_decimal_ascii #(
  parameter int QueueDepth = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               value_valid,
  output logic               value_stall,
  input  logic signed [31:0] value,
  output logic               text_valid,
  input  logic               text_stall,
  output logic [5:0]         character,
  output logic               last
);
  import sida_pkg::*;

  sida_item_t push_item;
  sida_item_t pop_item;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;

  sida_front u_front (
    .clk        (clk),
    .rst        (rst),
    .value_valid(value_valid),
    .value_stall(value_stall),
    .value      (value),
    .push       (push),
    .push_item  (push_item),
    .queue_full (full)
  );

  sida_queue #(.Depth(QueueDepth)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .full     (full),
    .pop      (pop),
    .pop_item (pop_item),
    .empty    (empty)
  );

  sida_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_item  (pop_item),
    .empty     (empty),
    .pop       (pop),
    .text_valid(text_valid),
    .text_stall(text_stall),
    .character (character),
    .last      (last)
  );

endmodule

// ===== src/sida_front.sv =====
// Front end: accepts a value, splits it into sign and unsigned magnitude, holds it for the queue.
module sida_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                value_valid,
  output logic                value_stall,
  input  logic signed [31:0]  value,
  output logic                push,
  output sida_pkg::sida_item_t push_item,
  input  logic                queue_full
);
  import sida_pkg::*;

  logic        held;
  logic        accept;
  logic [31:0] raw;
  sida_item_t  item;

  assign raw         = value;
  assign value_stall = held && queue_full;
  assign accept      = value_valid && !value_stall;
  assign push        = held && !queue_full;
  assign push_item   = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  // The magnitude is unsigned, so the most negative value maps to 2^31 without overflow.
  always_ff @(posedge clk) begin
    if (accept) begin
      item.neg <= raw[31];
      item.mag <= raw[31] ? (~raw + 32'd1) : raw;
    end
  end

endmodule

// ===== src/sida_queue.sv =====
// Small FIFO of classified items between the front end and the converter.
module sida_queue #(
  parameter int Depth = 2  // two or more entries
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sida_pkg::sida_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output sida_pkg::sida_item_t pop_item,
  output logic                 empty
);
  import sida_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  sida_item_t      entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full     = (count == CntW'(Depth));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== src/sida_back.sv =====
// Back end: divides the magnitude by ten digit by digit, then sends the text out MSB first.
module sida_back (
  input  logic                 clk,
  input  logic                 rst,
  input  sida_pkg::sida_item_t pop_item,
  input  logic                 empty,
  output logic                 pop,
  output logic                 text_valid,
  input  logic                 text_stall,
  output logic [5:0]           character,
  output logic                 last
);
  import sida_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMul  = 4'b0010,
    StDig  = 4'b0100,
    StEmit = 4'b1000
  } sida_state_t;

  sida_state_t       state;
  logic [31:0]       mag;
  logic [28:0]       quot;
  logic [63:0]       prod;
  logic [3:0]        q10;
  logic [3:0]        rem;
  logic [3:0]        digits [DigitMax];
  logic [DigitW-1:0] cnt;
  logic [DigitW-1:0] idx;
  logic              sign_pend;
  logic              out_load;

  assign pop      = (state == StIdle) && !empty;
  assign out_load = !text_valid || !text_stall;
  assign prod     = 64'(mag) * 64'(Recip);

  // Only the low four bits of mag - 10 * quot are needed, since the remainder is below ten.
  assign q10 = 4'({quot[3:0], 3'b000} + {4'b0000, quot[3:0], 1'b0});
  assign rem = mag[3:0] - q10;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= StIdle;
      text_valid <= 1'b0;
    end else begin
      if (state == StEmit && out_load) begin
        text_valid <= 1'b1;
      end else if (text_valid && !text_stall) begin
        text_valid <= 1'b0;
      end
      case (state)
        StIdle: begin
          if (!empty) begin
            state <= StMul;
          end
        end
        StMul: begin
          state <= StDig;
        end
        StDig: begin
          state <= (quot == '0) ? StEmit : StMul;
        end
        StEmit: begin
          if (out_load && !sign_pend && idx == '0) begin
            state <= StIdle;
          end
        end
        default: begin
          state <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      StIdle: begin
        if (!empty) begin
          mag       <= pop_item.mag;
          sign_pend <= pop_item.neg;
          cnt       <= '0;
        end
      end
      StMul: begin
        quot <= prod[63:RecipShift];
      end
      StDig: begin
        digits[cnt] <= rem;
        cnt         <= cnt + DigitW'(1);
        idx         <= cnt;
        mag         <= {3'b000, quot};
      end
      StEmit: begin
        if (out_load) begin
          if (sign_pend) begin
            character <= CharMinus;
            last      <= 1'b0;
            sign_pend <= 1'b0;
          end else begin
            character <= CharZero + {2'b00, digits[idx]};
            last      <= (idx == '0);
            idx       <= idx - DigitW'(1);
          end
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

endmodule

// ===== src/sida_check.sv =====
// Port-level checks for the converter, bound to the top level.
module sida_check (
  input logic               clk,
  input logic               rst,
  input logic               value_valid,
  input logic               value_stall,
  input logic signed [31:0] value,
  input logic               text_valid,
  input logic               text_stall,
  input logic [5:0]         character,
  input logic               last
);
  import sida_pkg::*;

  // A stalled input beat stays offered with the same value.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    value_valid && value_stall |=> value_valid && $stable(value))
    else $error("value beat changed while stalled");

  // A stalled beat keeps its character and last flag.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_stall |=> text_valid && $stable(character) && $stable(last))
    else $error("text beat changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (rst)
    text_valid |-> character == CharMinus || (character >= CharZero && character <= 6'd57))
    else $error("character is neither a digit nor a minus sign");

  // The minus sign always opens a run and never ends it.
  a_sign: assert property (@(posedge clk) disable iff (rst)
    text_valid && character == CharMinus |-> !last)
    else $error("minus sign flagged as last");

  // A negative number never has a leading zero right after its sign.
  a_lead: assert property (@(posedge clk) disable iff (rst)
    text_valid && !text_stall && character == CharMinus |=>
      !text_valid || (character != CharZero && character != CharMinus))
    else $error("bad character after minus sign");

endmodule

bind signed_int_to_decimal_ascii sida_check u_check (.*);
